// ===== sv/sti_pkg.sv =====
// sti_pkg: constants, codes and field widths shared by the scanline timing unit
// used by the channel interfaces and by scanline_timing_irq_unit
// no dependencies
package sti_pkg;

    localparam int unsigned CYCLES_W    = 16;
    localparam int unsigned LINE_CYC_W  = 10;
    localparam int unsigned IRQ_W       = 4;
    localparam int unsigned LINE_W      = 8;
    localparam int unsigned FRAME_CNT_W = 32;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [LINE_W-1:0]     FRAME_LINE      = 8'd144;
    localparam logic [LINE_W-1:0]     LAST_LINE       = 8'd158;
    localparam logic [LINE_CYC_W-1:0] LINE_CYC_RESET  = 10'd256;

    // interrupt bit positions
    localparam int unsigned IRQ_LINE_MATCH = 0;
    localparam int unsigned IRQ_VBL_TIMER  = 1;
    localparam int unsigned IRQ_VBLANK     = 2;
    localparam int unsigned IRQ_HBL_TIMER  = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_CYCLES   = 8'd0,
        REG_IRQ_ENABLE    = 8'd1,
        REG_HBLANK_RELOAD = 8'd2,
        REG_COMPARE_LINE  = 8'd3
    } t_reg_idx;

endpackage

// ===== sv/sti_ifs.sv =====
// sti_ifs: valid/ready channel interfaces of the scanline timing unit
// request, result and configuration write channels
// depends on sti_pkg
interface sti_req_if;
    logic                          valid;
    logic                          ready;
    logic [sti_pkg::CYCLES_W-1:0]  cycles_run;
    logic                          render;

    modport source (output valid, output cycles_run, output render, input ready);
    modport sink   (input valid, input cycles_run, input render, output ready);
endinterface

interface sti_res_if;
    logic                             valid;
    logic                             ready;
    logic [sti_pkg::LINE_W-1:0]       line_now;
    logic [sti_pkg::LINE_W-1:0]       lines_advanced;
    logic [sti_pkg::LINE_W-1:0]       lines_to_draw;
    logic                             frame_done;
    logic [sti_pkg::IRQ_W-1:0]        irq_raised;
    logic [sti_pkg::FRAME_CNT_W-1:0]  frames_total;

    modport source (output valid, output line_now, output lines_advanced,
                    output lines_to_draw, output frame_done, output irq_raised,
                    output frames_total, input ready);
    modport sink   (input valid, input line_now, input lines_advanced,
                    input lines_to_draw, input frame_done, input irq_raised,
                    input frames_total, output ready);
endinterface

interface sti_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sti_pkg::CFG_IDX_W-1:0]   index;
    logic [sti_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/scanline_timing_irq_unit.sv =====
// scanline_timing_irq_unit: display line timing and interrupt source
// bit-serial divider for lines advanced, scanline/frame/irq update
// depends on sti_pkg and the channel interfaces in sti_ifs.sv
//
//  channel  | dir | payload                                    | handshake
//  ---------+-----+--------------------------------------------+-------------
//  i_req    | in  | cycles_run, render                         | valid/ready
//  o_res    | out | line_now, lines_advanced, lines_to_draw,   | valid/ready
//           |     | frame_done, irq_raised, frames_total       |
//  i_cfg    | in  | index, data                                | valid/ready
//
//  a request passes through the restoring divider, one quotient bit a cycle, then
//  through the update state, which waits while the output register is still full
//  reset is synchronous, active low; state, counters and config registers reload
//  a request is taken only when the divider is idle
//  a result waits in the output register; the next request may be accepted
//  and divided meanwhile, and its update stalls until the result is taken
//  configuration writes are always accepted
module scanline_timing_irq_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sti_req_if.sink       i_req,
    sti_res_if.source     o_res,
    sti_cfg_if.sink       i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_UPDATE
    } t_state;

    localparam int unsigned CNT_W = $clog2(sti_pkg::CYCLES_W);
    localparam int unsigned LW    = sti_pkg::LINE_W;
    localparam int unsigned CW    = sti_pkg::LINE_CYC_W;

    t_state r_state;

    // configuration registers
    logic [CW-1:0]                  r_line_cycles;
    logic [sti_pkg::IRQ_W-1:0]      r_irq_enable;
    logic [LW-1:0]                  r_hblank_reload;
    logic [LW-1:0]                  r_compare_line;

    // timing state
    logic [LW-1:0]                  r_scanline;
    logic [LW-1:0]                  r_hblank_count;
    logic [sti_pkg::FRAME_CNT_W-1:0] r_frame_count;

    // divider: dividend shifts out at the top, quotient bits enter at the bottom
    logic [sti_pkg::CYCLES_W-1:0]   r_dvd;
    logic [CW-1:0]                  r_rem;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_render;

    // output register
    logic                           r_out_valid;
    logic [LW-1:0]                  r_o_line_now;
    logic [LW-1:0]                  r_o_lines_adv;
    logic [LW-1:0]                  r_o_lines_draw;
    logic                           r_o_frame_done;
    logic [sti_pkg::IRQ_W-1:0]      r_o_irq;

    // divider step
    logic [CW:0]                    w_trial;
    logic                           w_qbit;
    logic [CW:0]                    w_diff;

    // update cycle
    logic                           w_out_free;
    logic                           w_commit;
    logic [LW-1:0]                  w_adv;
    logic [LW-1:0]                  w_dist;
    logic                           w_frame;
    logic [LW-1:0]                  w_sum;
    logic                           w_wrap;
    logic [LW-1:0]                  n_scanline;
    logic                           w_hbl_run;
    logic [LW-1:0]                  w_hbl_loaded;
    logic [LW-1:0]                  w_hbl_dec;
    logic [LW-1:0]                  n_hblank_count;
    logic [sti_pkg::IRQ_W-1:0]      n_irq;
    logic [sti_pkg::FRAME_CNT_W-1:0] n_frame_count;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[sti_pkg::CYCLES_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_line_cycles});
    assign w_diff  = w_trial - {1'b0, r_line_cycles};

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_commit   = (r_state == S_UPDATE) && w_out_free;

    always_comb begin
        // zero line length or quotient above 255 saturates; quotient below 2
        // means cycles fell short of two lines, which counts as one line
        priority if (r_line_cycles == '0
                     || r_dvd[sti_pkg::CYCLES_W-1:LW] != '0) begin
            w_adv = '1;
        end else if (r_dvd[LW-1:1] == '0) begin
            w_adv = LW'(1);
        end else begin
            w_adv = r_dvd[LW-1:0];
        end

        w_dist  = sti_pkg::FRAME_LINE - r_scanline;
        w_frame = (w_dist != '0) && (w_dist <= w_adv);

        w_sum      = r_scanline + w_adv;
        w_wrap     = (w_sum > sti_pkg::LAST_LINE);
        n_scanline = w_wrap ? '0 : w_sum;

        // hblank timer: reload on zero, then count down
        w_hbl_run    = (r_hblank_reload != '0) && r_irq_enable[sti_pkg::IRQ_HBL_TIMER];
        w_hbl_loaded = (r_hblank_count == '0) ? r_hblank_reload : r_hblank_count;
        w_hbl_dec    = w_hbl_loaded - LW'(1);
        n_hblank_count = w_hbl_run ? w_hbl_dec : r_hblank_count;

        n_irq = '0;
        n_irq[sti_pkg::IRQ_VBL_TIMER] = w_wrap && r_irq_enable[sti_pkg::IRQ_VBL_TIMER];
        n_irq[sti_pkg::IRQ_VBLANK]    = w_frame && r_irq_enable[sti_pkg::IRQ_VBLANK];
        n_irq[sti_pkg::IRQ_HBL_TIMER] = w_hbl_run && (w_hbl_dec == '0);
        n_irq[sti_pkg::IRQ_LINE_MATCH] = (n_scanline == r_compare_line)
                                         && r_irq_enable[sti_pkg::IRQ_LINE_MATCH];

        n_frame_count = r_frame_count + sti_pkg::FRAME_CNT_W'(w_frame);
    end

    // configuration writes, out-of-range indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_cycles   <= sti_pkg::LINE_CYC_RESET;
            r_irq_enable    <= '0;
            r_hblank_reload <= '0;
            r_compare_line  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sti_pkg::REG_LINE_CYCLES:   r_line_cycles   <= i_cfg.data[CW-1:0];
                sti_pkg::REG_IRQ_ENABLE:    r_irq_enable    <= i_cfg.data[sti_pkg::IRQ_W-1:0];
                sti_pkg::REG_HBLANK_RELOAD: r_hblank_reload <= i_cfg.data[LW-1:0];
                sti_pkg::REG_COMPARE_LINE:  r_compare_line  <= i_cfg.data[LW-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, timing state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_scanline     <= '0;
            r_hblank_count <= '0;
            r_frame_count  <= '0;
            r_cnt          <= '0;
        end else begin
            // a new result may land in the same cycle the old one is taken
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_dvd    <= i_req.cycles_run;
                        r_render <= i_req.render;
                        r_rem    <= '0;
                        r_cnt    <= CNT_W'(sti_pkg::CYCLES_W - 1);
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dvd <= {r_dvd[sti_pkg::CYCLES_W-2:0], w_qbit};
                    r_rem <= w_qbit ? w_diff[CW-1:0] : w_trial[CW-1:0];
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (w_out_free) begin
                        r_scanline     <= n_scanline;
                        r_hblank_count <= n_hblank_count;
                        r_frame_count  <= n_frame_count;
                        r_o_line_now   <= n_scanline;
                        r_o_lines_adv  <= w_adv;
                        r_o_lines_draw <= r_render ? w_adv : '0;
                        r_o_frame_done <= w_frame;
                        r_o_irq        <= n_irq;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.line_now       = r_o_line_now;
    assign o_res.lines_advanced = r_o_lines_adv;
    assign o_res.lines_to_draw  = r_o_lines_draw;
    assign o_res.frame_done     = r_o_frame_done;
    assign o_res.irq_raised     = r_o_irq;
    assign o_res.frames_total   = r_frame_count;

`ifndef NO_ASSERTIONS
    // scanline never rests beyond the last line
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scanline <= sti_pkg::LAST_LINE)
        else $error("scanline beyond last line");

    // an advance is never zero
    a_adv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_lines_adv != '0))
        else $error("zero lines advanced");

    // lines to draw is either nothing or the full advance
    a_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_lines_draw == '0 || r_o_lines_draw == r_o_lines_adv))
        else $error("lines to draw mismatch");

    // frame counter moves by exactly the frame flag of a committed step
    a_frame_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_frame_count == $past(r_frame_count)
                      + sti_pkg::FRAME_CNT_W'($past(w_frame))))
        else $error("frame count step wrong");

    // timing state holds outside the update cycle
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_commit |=> ($stable(r_scanline) && $stable(r_hblank_count)))
        else $error("timing state changed without a commit");
`endif

endmodule

// ===== tb/sti_line_checker.sv =====
// sti_line_checker: watches the request, result and configuration channels of
// scanline_timing_irq_unit, predicts each result and compares it field by field
// depends on sti_pkg and the channel interfaces in sti_ifs.sv
module sti_line_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sti_req_if    i_req,
    sti_res_if    i_res,
    sti_cfg_if    i_cfg,
    output int    o_lines_due,
    output int    o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import sti_pkg::*;

    typedef struct packed {
        logic [LINE_W-1:0]      line_now;
        logic [LINE_W-1:0]      lines_advanced;
        logic [LINE_W-1:0]      lines_to_draw;
        logic                   frame_done;
        logic [IRQ_W-1:0]       irq_raised;
        logic [FRAME_CNT_W-1:0] frames_total;
    } t_line_result;

    // register copies
    logic [LINE_CYC_W-1:0]  line_len;
    logic [IRQ_W-1:0]       irq_en;
    logic [LINE_W-1:0]      hbl_reload;
    logic [LINE_W-1:0]      cmp_line;

    // timing state copies
    logic [LINE_W-1:0]      scan_line;
    logic [LINE_W-1:0]      hbl_count;
    logic [FRAME_CNT_W-1:0] frame_cnt;

    t_line_result lines_due[$];
    t_line_result want;
    int           faults = 0;

    assign o_mismatches = faults;

    task automatic report_fault(input string what);
        $display("%0t ns sti_line_checker: %s", $time, what);
        faults++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_fault($sformatf("%s is %0h, %0h due", name, got, exp_val));
    endtask

    // one line slot: advance, wrap past the last line, frame, hblank timer, match
    function automatic t_line_result advance_scanline(input logic [CYCLES_W-1:0] cyc,
                                                      input logic draw);
        t_line_result      r;
        int unsigned       cyc_u;
        int unsigned       len_u;
        int unsigned       quot;
        logic [LINE_W-1:0] adv;
        logic [LINE_W-1:0] gap_to_frame;
        logic              hit;
        logic [IRQ_W-1:0]  irq;

        cyc_u = cyc;
        len_u = line_len;
        if (len_u == 0)
            quot = 255;
        else if (cyc_u >= 2 * len_u)
            quot = cyc_u / len_u;
        else
            quot = 1;
        adv  = (quot > 255) ? 8'd255 : LINE_W'(quot);
        gap_to_frame = FRAME_LINE - scan_line;
        hit  = (gap_to_frame != 0) && (gap_to_frame <= adv);
        irq  = '0;

        scan_line = scan_line + adv;
        if (scan_line > LAST_LINE) begin
            scan_line = '0;
            if (irq_en[IRQ_VBL_TIMER])
                irq[IRQ_VBL_TIMER] = 1'b1;
        end
        if (hit) begin
            if (irq_en[IRQ_VBLANK])
                irq[IRQ_VBLANK] = 1'b1;
            frame_cnt = frame_cnt + 1'b1;
        end
        if (hbl_reload != 0 && irq_en[IRQ_HBL_TIMER]) begin
            if (hbl_count == 0)
                hbl_count = hbl_reload;
            if (hbl_count != 0)
                hbl_count = hbl_count - 1'b1;
            if (hbl_count == 0)
                irq[IRQ_HBL_TIMER] = 1'b1;
        end
        if (scan_line == cmp_line && irq_en[IRQ_LINE_MATCH])
            irq[IRQ_LINE_MATCH] = 1'b1;

        r.line_now       = scan_line;
        r.lines_advanced = adv;
        r.lines_to_draw  = draw ? adv : '0;
        r.frame_done     = hit;
        r.irq_raised     = irq;
        r.frames_total   = frame_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_len   = LINE_CYC_RESET;
            irq_en     = '0;
            hbl_reload = '0;
            cmp_line   = '0;
            scan_line  = '0;
            hbl_count  = '0;
            frame_cnt  = '0;
            lines_due.delete();
        end else begin
            // results first: a request taken at this edge cannot be answered yet
            if (i_res.valid && i_res.ready) begin
                if (lines_due.size() == 0) begin
                    report_fault("result with no request outstanding");
                end else begin
                    want = lines_due.pop_front();
                    check_field("line_now", i_res.line_now, want.line_now);
                    check_field("lines_advanced", i_res.lines_advanced,
                                want.lines_advanced);
                    check_field("lines_to_draw", i_res.lines_to_draw, want.lines_to_draw);
                    check_field("frame_done", i_res.frame_done, want.frame_done);
                    check_field("irq_raised", i_res.irq_raised, want.irq_raised);
                    check_field("frames_total", i_res.frames_total, want.frames_total);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_LINE_CYCLES:   line_len   = i_cfg.data[LINE_CYC_W-1:0];
                    REG_IRQ_ENABLE:    irq_en     = i_cfg.data[IRQ_W-1:0];
                    REG_HBLANK_RELOAD: hbl_reload = i_cfg.data[LINE_W-1:0];
                    REG_COMPARE_LINE:  cmp_line   = i_cfg.data[LINE_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready)
                lines_due.push_back(advance_scanline(i_req.cycles_run, i_req.render));
        end
        o_lines_due = lines_due.size();
    end

endmodule

// ===== tb/tb_scanline_timing_irq_unit.sv =====
// tb_scanline_timing_irq_unit: stimulus and verdict for scanline_timing_irq_unit
// directed line slots, then randomised phases with register changes between them
// depends on sti_pkg, sti_ifs.sv, the block and sti_line_checker
module tb_scanline_timing_irq_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sti_pkg::*;

    localparam int unsigned ITEM_TARGET = 1350;   // requests, directed part included
    localparam int unsigned HOLD_CYCLES = 200;    // long receiver hold-off
    localparam int unsigned TAIL_CYCLES = 40;     // settling time before the verdict

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sti_req_if req_ch();
    sti_res_if res_ch();
    sti_cfg_if cfg_ch();

    int lines_due;
    int mismatches;

    // shaping knobs for the sender and the receiver, and stimulus bookkeeping
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    bit          rx_hold_req = 1'b0;
    int unsigned lines_sent = 0;
    int unsigned cur_line_len = LINE_CYC_RESET;

    scanline_timing_irq_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    sti_line_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_lines_due  (lines_due),
        .o_mismatches (mismatches)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #10ms;
        $display("tb_scanline_timing_irq_unit: FAIL");
        $finish;
    end

    // result side: a random stall before each result, none in
    // quiet phases, and a long counted hold-off whenever one is requested
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        res_ch.ready = 1'b0;
        stall_left = $urandom_range(0, 9);
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                stall_left = rx_quiet ? 0 : $urandom_range(0, 9);
            if (rx_hold_req) begin
                hold_left = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            @(negedge clk);
            if (!rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // offer one line slot after a random gap; called and returns at a falling
    // edge, valid left high so back-to-back requests keep it raised
    task automatic send_line(input logic [CYCLES_W-1:0] cyc, input logic draw);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cycles_run <= cyc;
        req_ch.render     <= draw;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
        lines_sent++;
    endtask

    // register write with random junk above the field; valid is dropped and seen low
    // before the task returns, so that consecutive writes never re-raise it in one step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                             input int unsigned width);
        logic [CFG_DATA_W-1:0] word;
        word = $urandom;
        word = (word << width) | value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= word;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // stop offering and wait for every outstanding result; the block is idle after
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (lines_due != 0) @(negedge clk);
    endtask

    // new register setting for a phase, extremes weighted in
    task automatic shuffle_timing_regs();
        int unsigned sel;
        int unsigned val;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            val = 1;
        else if (sel < 20)
            val = 1023;
        else if (sel < 25)
            val = 0;                      // divide by zero, saturates
        else
            val = $urandom_range(1, 1023);
        cur_line_len = val;
        write_reg(REG_LINE_CYCLES, val, LINE_CYC_W);

        val = ($urandom_range(0, 9) < 4) ? 15 : $urandom_range(0, 15);
        write_reg(REG_IRQ_ENABLE, val, IRQ_W);

        sel = $urandom_range(0, 99);
        if (sel < 15)
            val = 0;                      // hblank timer off
        else if (sel < 25)
            val = 255;
        else if (sel < 35)
            val = $urandom_range(0, 255);
        else
            val = $urandom_range(1, 10);
        write_reg(REG_HBLANK_RELOAD, val, LINE_W);

        val = ($urandom_range(0, 9) < 7) ? $urandom_range(0, LAST_LINE)
                                         : $urandom_range(0, 255);
        write_reg(REG_COMPARE_LINE, val, LINE_W);

        // an index past the last register must leave everything as it was
        if ($urandom_range(0, 4) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_COMPARE_LINE + 1, 255)), $urandom, 0);
    endtask

    // cycle counts mostly near one line so the scanline walks through every
    // line, with multi-line jumps, exact boundaries and full-range values mixed in
    function automatic logic [CYCLES_W-1:0] pick_cycles(input int unsigned len);
        int unsigned sel;
        int unsigned v;
        sel = $urandom_range(0, 99);
        if (len == 0 || sel >= 80 && sel < 92)
            v = $urandom_range(0, 65535);
        else if (sel < 55)
            v = $urandom_range(0, 2 * len - 1);
        else if (sel < 80)
            v = len * $urandom_range(2, 12) + $urandom_range(0, len - 1);
        else if (sel < 96)
            v = 2 * len - $urandom_range(0, 1);
        else
            v = $urandom_range(0, 1) ? 65535 : 0;
        return (v > 65535) ? 16'hFFFF : CYCLES_W'(v);
    endfunction

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;

        req_ch.valid      = 1'b0;
        req_ch.cycles_run = '0;
        req_ch.render     = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset line length, every interrupt enabled, short hblank period
        write_reg(REG_IRQ_ENABLE, 15, IRQ_W);
        write_reg(REG_HBLANK_RELOAD, 2, LINE_W);
        write_reg(REG_COMPARE_LINE, 1, LINE_W);
        write_reg(CFG_IDX_W'(REG_COMPARE_LINE + 1), $urandom, 0);  // ignored
        write_reg({CFG_IDX_W{1'b1}}, $urandom, 0);                // ignored
        send_line(16'd0, 1'b1);          // one line, hits compare line
        send_line(16'hFFFF, 1'b1);       // quotient 255, scanline wraps past 255
        send_line(16'd511, 1'b0);        // just under two lines still counts one
        send_line(16'd512, 1'b1);        // exactly two lines
        send_line(16'd36864, 1'b1);      // 144 lines in one slot
        drain_results();

        // shortest line: large advances saturate
        write_reg(REG_LINE_CYCLES, 1, LINE_CYC_W);
        send_line(16'd0, 1'b1);
        send_line(16'd1, 1'b0);
        send_line(16'd2, 1'b1);
        send_line(16'd300, 1'b1);
        send_line(16'hFFFF, 1'b0);
        drain_results();

        // zero line length reads as a saturated advance
        write_reg(REG_LINE_CYCLES, 0, LINE_CYC_W);
        send_line(16'd0, 1'b1);
        send_line(16'd1234, 1'b0);
        drain_results();

        // longest line, widest hblank period, match on line zero
        write_reg(REG_LINE_CYCLES, 1023, LINE_CYC_W);
        write_reg(REG_HBLANK_RELOAD, 255, LINE_W);
        write_reg(REG_COMPARE_LINE, 0, LINE_W);
        send_line(16'd2045, 1'b1);
        send_line(16'd2046, 1'b1);
        send_line(16'hFFFF, 1'b1);
        send_line(16'd0, 1'b0);
        drain_results();
        cur_line_len = 1023;

        // random phases; each ends with the sender waiting for every result
        phase = 0;
        while (lines_sent < ITEM_TARGET) begin
            phase++;
            shuffle_timing_regs();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 80);
            if (phase == 3 || phase == 11) begin
                // receiver holds off while requests keep coming: the block fills
                // its output register and divider, then stalls its input
                rx_hold_req = 1'b1;
                tx_quiet = 1'b1;
            end
            repeat (n) send_line(pick_cycles(cur_line_len), 1'($urandom));
            drain_results();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb_scanline_timing_irq_unit: PASS");
        else
            $display("tb_scanline_timing_irq_unit: FAIL");
        $finish;
    end

endmodule
